// ===== hdl/pcsc_pkg.sv =====
// Shared types and constants for the piecewise curve segment coefficient block.
// Used by pcsc_knot_cell, pcsc_div and piecewise_curve_segment_coefficients.
package pcsc_pkg;

    localparam int MAX_KNOTS = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;

    // divider operand widths
    localparam int NUM_W = 36;
    localparam int DEN_W = 33;

    // item kinds carried on tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // one knot as held in a cell
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     sharp;
    } knot_t;

    // search chain between neighboring cells
    typedef struct packed {
        logic found;
    } chain_t;

endpackage

// ===== hdl/pcsc_knot_cell.sv =====
// One knot slot of the table row, with its link of the search chain.
// Depends on pcsc_pkg.
module pcsc_knot_cell
(
    input  logic                             clk,
    input  logic [pcsc_pkg::IDX_W-1:0]       cell_index,
    input  logic                             wr_en,
    input  pcsc_pkg::knot_t                  wr_knot,
    input  logic [pcsc_pkg::CNT_W-1:0]       knot_num,
    input  logic signed [pcsc_pkg::DATA_W-1:0] query,
    input  pcsc_pkg::chain_t                 chain_in,
    output pcsc_pkg::chain_t                 chain_out,
    output logic                             hit,
    output pcsc_pkg::knot_t                  knot
);

    pcsc_pkg::knot_t knot_reg;
    logic            in_use;
    logic            ge;

    // knot storage, written by a knot write transfer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_reg <= wr_knot;
        end
    end

    // slot 0 starts the scan, so only slots 1..n-1 take part
    assign in_use = (cell_index != '0) && ({1'b0, cell_index} < knot_num);
    assign ge     = (knot_reg.x >= query);

    // first in-use slot at or above the query claims the hit
    assign hit             = in_use && ge && !chain_in.found;
    assign chain_out.found = chain_in.found || (in_use && ge);
    assign knot            = knot_reg;

endmodule

// ===== hdl/pcsc_div.sv =====
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncated, saturated.
// One quotient bit per cycle. Depends on pcsc_pkg.
module pcsc_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pcsc_pkg::NUM_W-1:0] num,
    input  logic signed [pcsc_pkg::DEN_W-1:0] den,
    output logic                              done,
    output logic signed [pcsc_pkg::DATA_W-1:0] quot
);

    localparam int DVD_W = pcsc_pkg::NUM_W + pcsc_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [DVD_W-1:0]             dvd_reg;
    logic [pcsc_pkg::DEN_W-1:0]   dvs_reg;
    logic [pcsc_pkg::DEN_W-1:0]   rem_reg;
    logic                         neg_reg;
    logic signed [pcsc_pkg::DATA_W-1:0] quot_reg;

    logic [pcsc_pkg::NUM_W-1:0]   num_mag;
    logic [pcsc_pkg::DEN_W-1:0]   den_mag;
    logic [pcsc_pkg::DEN_W:0]     rem_sh;
    logic                         q_bit;
    logic [pcsc_pkg::DEN_W:0]     rem_sub;
    logic [DVD_W-1:0]             q_final;
    logic signed [pcsc_pkg::DATA_W-1:0] q_sat;

    assign num_mag = num[pcsc_pkg::NUM_W-1] ? pcsc_pkg::NUM_W'(-num) : pcsc_pkg::NUM_W'(num);
    assign den_mag = den[pcsc_pkg::DEN_W-1] ? pcsc_pkg::DEN_W'(-den) : pcsc_pkg::DEN_W'(den);

    // restoring step
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign q_final = {dvd_reg[DVD_W-2:0], q_bit};

    // saturate the magnitude and apply the sign
    always_comb
    begin
        if (!neg_reg)
        begin
            if (q_final > DVD_W'({1'b0, {(pcsc_pkg::DATA_W-1){1'b1}}}))
                q_sat = {1'b0, {(pcsc_pkg::DATA_W-1){1'b1}}};
            else
                q_sat = pcsc_pkg::DATA_W'(q_final);
        end
        else
        begin
            if (q_final > DVD_W'({1'b1, {(pcsc_pkg::DATA_W-1){1'b0}}}))
                q_sat = {1'b1, {(pcsc_pkg::DATA_W-1){1'b0}}};
            else
                q_sat = pcsc_pkg::DATA_W'(-q_final);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    // zero divisor: largest value of the numerator's sign, zero for a zero numerator
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DVD_W - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[pcsc_pkg::NUM_W-1] ^ den[pcsc_pkg::DEN_W-1];
            dvd_reg <= {num_mag, {pcsc_pkg::FRAC_BITS{1'b0}}};
            dvs_reg <= den_mag;
            rem_reg <= '0;
            if (num == '0)
                quot_reg <= '0;
            else if (num[pcsc_pkg::NUM_W-1])
                quot_reg <= {1'b1, {(pcsc_pkg::DATA_W-1){1'b0}}};
            else
                quot_reg <= {1'b0, {(pcsc_pkg::DATA_W-1){1'b1}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? pcsc_pkg::DEN_W'(rem_sub) : pcsc_pkg::DEN_W'(rem_sh);
            dvd_reg <= q_final;
            if (cnt_reg == '0)
                quot_reg <= q_sat;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/piecewise_curve_segment_coefficients.sv =====
// Top level: knot table as a row of cells, span search, coefficient sequencer.
// Depends on pcsc_pkg, pcsc_knot_cell and pcsc_div.
//
// channel | signals                         | carries
// s_axis  | tvalid tready tdata tuser       | knot write or query
// m_axis  | tvalid tready tdata             | segment coefficients
// cfg     | cfg_wr_en cfg_wr_data           | knot count
//
// A query needs no division, one division or three, each done in turn by the
// one-bit-per-cycle divider; a zero divisor skips the iteration. Reset clears
// control state only; table contents are undefined until written. A result held
// by a stalled m_axis blocks the next query at the output stage; input is taken
// only when the sequencer idles.
module piecewise_curve_segment_coefficients
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,   // knot_count
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // knot_index[3:0], point_x, point_y, sharp_flag, pad
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata   // coef_const, coef_slope, coef_curve, start, end
);

    localparam int DW = pcsc_pkg::DATA_W;
    localparam int NK = pcsc_pkg::MAX_KNOTS;
    localparam int IW = pcsc_pkg::IDX_W;
    localparam int CW = pcsc_pkg::CNT_W;
    localparam int PW = 2 * DW + 1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_SPAN  = 8'b0000_0100,
        ST_DIV_A = 8'b0000_1000,
        ST_DIV_B = 8'b0001_0000,
        ST_DIV_C = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic   out_pend_reg;

    logic [CW-1:0]        count_reg;
    logic signed [DW-1:0] q_reg;
    logic [IW-1:0]        k0_reg;
    logic [IW-1:0]        k1_reg;
    logic                 three_reg;
    logic signed [DW-1:0] x0_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [DW-1:0] s0_reg, s1_reg;
    logic signed [DW-1:0] c0_reg, c1_reg, c2_reg, xs_reg, xe_reg;
    logic [PW-1:0]        prod_reg;
    logic                 pneg_reg;

    logic                 m_valid_reg;
    logic [159:0]         m_data_reg;

    logic                 div_start;
    logic signed [pcsc_pkg::NUM_W-1:0] div_num;
    logic signed [pcsc_pkg::DEN_W-1:0] div_den;
    logic                 div_done;
    logic signed [DW-1:0] div_quot;

    logic                 s_fire;
    pcsc_pkg::knot_t      wr_knot;
    pcsc_pkg::knot_t      knots [NK];
    pcsc_pkg::chain_t     chain [NK+1];
    logic [NK-1:0]        hits;
    logic [CW-1:0]        n_use;
    logic [CW-1:0]        nm1;
    logic [IW-1:0]        hit_idx;

    // clamp of the count to the table size
    assign n_use = (count_reg > CW'(NK)) ? CW'(NK) : count_reg;
    assign nm1   = n_use - 1'b1;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign wr_knot.x     = s_axis_tdata[35:4];
    assign wr_knot.y     = s_axis_tdata[67:36];
    assign wr_knot.sharp = s_axis_tdata[68];

    // row of knot cells with the search chain
    assign chain[0].found = 1'b0;
    for (genvar i = 0; i < NK; i++)
    begin : g_cell
        pcsc_knot_cell u_cell
        (
            .clk        (clk),
            .cell_index (IW'(i)),
            .wr_en      (s_fire && (s_axis_tuser == pcsc_pkg::ACT_WRITE)
                         && (s_axis_tdata[3:0] == IW'(i))),
            .wr_knot    (wr_knot),
            .knot_num   (n_use),
            .query      (q_reg),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .hit        (hits[i]),
            .knot       (knots[i])
        );
    end

    // hit slot number, at most one hit is set
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < NK; i++)
        begin
            if (hits[i])
                hit_idx = hit_idx | IW'(i);
        end
    end

    // span widening across non-sharp knots
    function automatic logic is_sharp(input logic [IW-1:0] k, input logic [CW-1:0] last,
                                      input logic sh);
        return (k == '0) || ({1'b0, k} == last) || sh;
    endfunction

    logic [IW-1:0] e_k0, e_k1;
    always_comb
    begin
        e_k0 = k0_reg;
        e_k1 = k1_reg;
        for (int s = 0; s < 2; s++)
        begin
            if ((e_k1 - e_k0) < IW'(2) && !is_sharp(e_k1, nm1, knots[e_k1].sharp))
                e_k1 = e_k1 + 1'b1;
        end
        for (int s = 0; s < 2; s++)
        begin
            if ((e_k1 - e_k0) < IW'(2) && !is_sharp(e_k0, nm1, knots[e_k0].sharp))
                e_k0 = e_k0 - 1'b1;
        end
    end

    logic [IW-1:0] e_k0p1, e_k0p2;
    assign e_k0p1 = e_k0 + 1'b1;
    assign e_k0p2 = e_k0 + IW'(2);

    // final slope: s1 - (c2 * dx1) / 2^(FRAC_BITS+1), saturated
    logic [PW-1-pcsc_pkg::FRAC_BITS-1:0] hm_mag;
    logic signed [PW-pcsc_pkg::FRAC_BITS-1:0] hm;
    logic signed [PW-pcsc_pkg::FRAC_BITS:0]   slope_wide;
    logic signed [DW-1:0]                      slope_sat;
    assign hm_mag     = prod_reg[PW-1:pcsc_pkg::FRAC_BITS+1];
    assign hm         = pneg_reg ? -$signed({1'b0, hm_mag}) : $signed({1'b0, hm_mag});
    assign slope_wide = (PW-pcsc_pkg::FRAC_BITS+1)'(s1_reg) - (PW-pcsc_pkg::FRAC_BITS+1)'(hm);
    always_comb
    begin
        if (slope_wide > (PW-pcsc_pkg::FRAC_BITS+1)'(signed'({1'b0, {(DW-1){1'b1}}})))
            slope_sat = {1'b0, {(DW-1){1'b1}}};
        else if (slope_wide < -(PW-pcsc_pkg::FRAC_BITS+1)'(signed'({1'b0, 1'b1,
                 {(DW-1){1'b0}}})))
            slope_sat = {1'b1, {(DW-1){1'b0}}};
        else
            slope_sat = DW'(slope_wide);
    end

    // magnitudes for the slope correction product
    logic signed [DW:0] dx1;
    logic [DW-1:0]      c2_mag;
    logic [DW:0]        dx1_mag;
    assign dx1     = (DW+1)'(x2_reg) - (DW+1)'(x1_reg);
    assign c2_mag  = c2_reg[DW-1] ? DW'(-c2_reg) : DW'(c2_reg);
    assign dx1_mag = dx1[DW] ? (DW+1)'(-dx1) : (DW+1)'(dx1);

    pcsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // divider launch and operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            ST_SPAN:
            begin
                div_start = (n_use >= CW'(2)) && (e_k0 != e_k1);
                div_num   = pcsc_pkg::NUM_W'(knots[e_k0p1].y) - pcsc_pkg::NUM_W'(knots[e_k0].y);
                div_den   = pcsc_pkg::DEN_W'(knots[e_k0p1].x) - pcsc_pkg::DEN_W'(knots[e_k0].x);
            end
            ST_DIV_A:
            begin
                div_start = div_done && three_reg;
                div_num   = pcsc_pkg::NUM_W'(y2_reg) - pcsc_pkg::NUM_W'(y1_reg);
                div_den   = pcsc_pkg::DEN_W'(x2_reg) - pcsc_pkg::DEN_W'(x1_reg);
            end
            ST_DIV_B:
            begin
                div_start = div_done;
                div_num   = (pcsc_pkg::NUM_W'(div_quot) - pcsc_pkg::NUM_W'(s0_reg)) <<< 1;
                div_den   = pcsc_pkg::DEN_W'(x2_reg) - pcsc_pkg::DEN_W'(x0_reg);
            end
            ST_IDLE, ST_SCAN, ST_DIV_C, ST_MUL, ST_FIN:
            begin
                div_start = 1'b0;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            out_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;

            // result valid: loaded from the final step, cleared on a transfer
            if ((state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready))
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire && (s_axis_tuser == pcsc_pkg::ACT_EVAL))
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    state_reg <= ST_SPAN;
                end
                ST_SPAN:
                begin
                    if (div_start)
                        state_reg <= ST_DIV_A;
                    else
                    begin
                        state_reg    <= ST_FIN;
                        out_pend_reg <= 1'b1;
                    end
                end
                ST_DIV_A:
                begin
                    if (div_done)
                    begin
                        if (three_reg)
                            state_reg <= ST_DIV_B;
                        else
                        begin
                            state_reg    <= ST_FIN;
                            out_pend_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV_B:
                begin
                    if (div_done)
                        state_reg <= ST_DIV_C;
                end
                ST_DIV_C:
                begin
                    if (div_done)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg    <= ST_FIN;
                    out_pend_reg <= 1'b1;
                end
                ST_FIN:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        out_pend_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                    q_reg <= s_axis_tdata[35:4];
            end
            ST_SCAN:
            begin
                if (q_reg <= knots[0].x)
                begin
                    k0_reg <= '0;
                    k1_reg <= '0;
                end
                else if (q_reg >= knots[nm1[IW-1:0]].x)
                begin
                    k0_reg <= nm1[IW-1:0];
                    k1_reg <= nm1[IW-1:0];
                end
                else
                begin
                    k0_reg <= hit_idx - 1'b1;
                    k1_reg <= hit_idx;
                end
            end
            ST_SPAN:
            begin
                c1_reg    <= '0;
                c2_reg    <= '0;
                three_reg <= (n_use >= CW'(2)) && (e_k1 == e_k0p2);
                x0_reg    <= knots[e_k0].x;
                x1_reg    <= knots[e_k0p1].x;
                x2_reg    <= knots[e_k0p2].x;
                y1_reg    <= knots[e_k0p1].y;
                y2_reg    <= knots[e_k0p2].y;
                if (n_use == '0)
                begin
                    c0_reg <= '0;
                    xs_reg <= q_reg;
                    xe_reg <= q_reg;
                end
                else if (n_use == CW'(1))
                begin
                    c0_reg <= knots[0].y;
                    xs_reg <= q_reg;
                    xe_reg <= q_reg;
                end
                else if (e_k0 == e_k1)
                begin
                    c0_reg <= knots[e_k1].y;
                    xs_reg <= knots[e_k1].x;
                    xe_reg <= knots[e_k1].x;
                end
                else
                begin
                    c0_reg <= knots[e_k0p1].y;
                    xs_reg <= knots[e_k0p1].x;
                    xe_reg <= (e_k1 == e_k0p2) ? knots[e_k0p2].x : knots[e_k0p1].x;
                end
            end
            ST_DIV_A:
            begin
                if (div_done)
                begin
                    s0_reg <= div_quot;
                    c1_reg <= div_quot;
                end
            end
            ST_DIV_B:
            begin
                if (div_done)
                    s1_reg <= div_quot;
            end
            ST_DIV_C:
            begin
                if (div_done)
                    c2_reg <= div_quot;
            end
            ST_MUL:
            begin
                prod_reg <= PW'(c2_mag) * PW'(dx1_mag);
                pneg_reg <= c2_reg[DW-1] ^ dx1[DW];
            end
            ST_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                    m_data_reg <= {xe_reg, xs_reg, c2_reg,
                                   three_reg ? slope_sat : c1_reg, c0_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // divider completes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_A || state_reg == ST_DIV_B
                      || state_reg == ST_DIV_C))
        else $error("divider finished outside a divide step");

    // a query closes the input until its result is out
    a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser == pcsc_pkg::ACT_EVAL) |=> !s_axis_tready)
        else $error("input open while a query is in flight");

    // a new result appears only from the final step with a pending result
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_FIN && $past(out_pend_reg)))
        else $error("result issued outside the final step");

endmodule
